// ----- design/lnf_pkg.sv -----
// lnf_pkg: shared types and constants of the lcd number formatter
// control word layout, sequencer step codes, status bundle
// no dependencies
package lnf_pkg;

  localparam int STEP_W = 3;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_CURSOR = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SIGN   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_PUSH   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_DONE   = 3'd6;

  // format modes
  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_BIN  = 2'd3;

  // display lines that get a cursor command
  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
  localparam logic [7:0] LINE_TWO_BASE  = 8'h40;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_PLUS      = 8'h2B;
  localparam logic [7:0] CHAR_MINUS     = 8'h2D;

  // ceil(2^35 / 10): q = (v * RECIP_TEN) >> 35 is exact for any 32-bit v
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_CURSOR,
    EMIT_SIGN,
    EMIT_DIGIT
  } emit_t;

  typedef enum logic [1:0] {
    COND_NONE,    // fall through to next step
    COND_ALWAYS,  // unconditional jump
    COND_DONE,    // all digits converted
    COND_MORE     // more than one digit still stacked
  } cond_t;

  typedef struct packed {
    logic              wait_in;
    emit_t             emit;
    logic              do_mul;
    logic              do_push;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic go;
    logic count_done;
    logic count_more;
    logic count_zero;
  } status_t;

endpackage

// ----- design/lnf_if.sv -----
// lnf_if: valid/ready channel interfaces of the lcd number formatter
// lnf_in_if carries one number to format, lnf_out_if one display bus write
// no dependencies
interface lnf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  line;
  logic [4:0]  column;
  logic [15:0] number;
  logic [4:0]  length;

  modport source(output valid, opcode, line, column, number, length, input ready);
  modport sink(input valid, opcode, line, column, number, length, output ready);
endinterface

interface lnf_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [7:0] bus_byte;
  logic       last;

  modport source(output valid, reg_select, bus_byte, last, input ready);
  modport sink(input valid, reg_select, bus_byte, last, output ready);
endinterface

// ----- design/lnf_sequencer.sv -----
// lnf_sequencer: step counter and microcode rom of the lcd number formatter
// depends on lnf_pkg (ctrl_t, status_t, step codes)
module lnf_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  lnf_pkg::status_t st,
  output lnf_pkg::ctrl_t   ctrl
);

  logic [lnf_pkg::STEP_W-1:0] step;
  logic [lnf_pkg::STEP_W-1:0] step_next;
  logic                       take;

  // microcode rom
  always_comb begin
    ctrl = '{wait_in: 1'b0, emit: lnf_pkg::EMIT_NONE, do_mul: 1'b0, do_push: 1'b0,
             cond: lnf_pkg::COND_NONE, target: lnf_pkg::STEP_IDLE};
    case (step)
      lnf_pkg::STEP_IDLE: begin
        ctrl.wait_in = 1'b1;
      end
      lnf_pkg::STEP_CURSOR: begin
        ctrl.emit = lnf_pkg::EMIT_CURSOR;
      end
      lnf_pkg::STEP_SIGN: begin
        ctrl.emit = lnf_pkg::EMIT_SIGN;
      end
      lnf_pkg::STEP_MUL: begin
        ctrl.do_mul = 1'b1;
        ctrl.cond   = lnf_pkg::COND_DONE;
        ctrl.target = lnf_pkg::STEP_EMIT;
      end
      lnf_pkg::STEP_PUSH: begin
        ctrl.do_push = 1'b1;
        ctrl.cond    = lnf_pkg::COND_ALWAYS;
        ctrl.target  = lnf_pkg::STEP_MUL;
      end
      lnf_pkg::STEP_EMIT: begin
        ctrl.emit   = lnf_pkg::EMIT_DIGIT;
        ctrl.cond   = lnf_pkg::COND_MORE;
        ctrl.target = lnf_pkg::STEP_EMIT;
      end
      default: begin
        ctrl.cond   = lnf_pkg::COND_ALWAYS;
        ctrl.target = lnf_pkg::STEP_IDLE;
      end
    endcase
  end

  always_comb begin
    case (ctrl.cond)
      lnf_pkg::COND_ALWAYS: take = 1'b1;
      lnf_pkg::COND_DONE:   take = st.count_done;
      lnf_pkg::COND_MORE:   take = st.count_more;
      default:              take = 1'b0;
    endcase
    if (!st.go) begin
      step_next = step;
    end else if (take) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + lnf_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lnf_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- design/lnf_datapath.sv -----
// lnf_datapath: operand registers, divide-by-base unit, digit stack, output register
// depends on lnf_pkg, lnf_in_if, lnf_out_if
module lnf_datapath #(
  parameter int MAX_DIGITS  = 16,
  parameter int NUMBER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  lnf_in_if.sink           item,
  lnf_out_if.source        bus,
  input  lnf_pkg::ctrl_t   ctrl,
  output lnf_pkg::status_t st
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int VAL_W = NUMBER_BITS;

  logic [1:0]       mode;
  logic [1:0]       line;
  logic [4:0]       column;
  logic [VAL_W-1:0] value;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] count;
  logic [63:0]      prod;
  logic [3:0]       stack [MAX_DIGITS];

  logic             out_valid;
  logic             out_rs;
  logic [7:0]       out_byte;
  logic             out_last;

  logic             in_fire;
  logic             emit_want;
  logic             emit_fire;
  logic             stall;
  logic             line_hit;
  logic             signed_mode;
  logic [CNT_W-1:0] len_sat;
  logic [31:0]      val32;
  logic [28:0]      q_ten;
  logic [31:0]      q32;
  logic [31:0]      diff;
  logic [VAL_W-1:0] q_sel;
  logic [3:0]       rem_sel;
  logic [7:0]       cursor_byte;
  logic             emit_rs;
  logic [7:0]       emit_byte;
  logic             emit_last;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return lnf_pkg::CHAR_ZERO + {4'b0, d};
    end
    return lnf_pkg::CHAR_UPPER_A + {4'b0, d} - 8'd10;
  endfunction

  assign item.ready     = ctrl.wait_in;
  assign in_fire        = item.valid && ctrl.wait_in;
  assign line_hit       = (line == lnf_pkg::LINE_ONE) || (line == lnf_pkg::LINE_TWO);
  assign signed_mode    = (mode == lnf_pkg::MODE_SDEC);

  always_comb begin
    if (32'(item.length) > 32'(MAX_DIGITS)) begin
      len_sat = CNT_W'(MAX_DIGITS);
    end else begin
      len_sat = CNT_W'(item.length);
    end
  end

  // division by the base: reciprocal multiply for ten, shifts for 16 and 2
  assign val32 = 32'(value);
  assign q_ten = prod[63:lnf_pkg::RECIP_SHIFT];
  assign q32   = {3'b0, q_ten};
  assign diff  = val32 - (q32 << 3) - (q32 << 1);

  always_comb begin
    case (mode)
      lnf_pkg::MODE_HEX: begin
        q_sel   = value >> 4;
        rem_sel = value[3:0];
      end
      lnf_pkg::MODE_BIN: begin
        q_sel   = value >> 1;
        rem_sel = {3'b0, value[0]};
      end
      default: begin
        q_sel   = VAL_W'(q_ten);
        rem_sel = diff[3:0];
      end
    endcase
  end

  assign cursor_byte = lnf_pkg::CMD_SET_CURSOR | ({3'b0, column} - 8'd1 +
                       ((line == lnf_pkg::LINE_TWO) ? lnf_pkg::LINE_TWO_BASE : 8'd0));

  always_comb begin
    emit_want = 1'b0;
    emit_rs   = 1'b1;
    emit_byte = digit_char(stack[0]);
    emit_last = (count == CNT_W'(1));
    case (ctrl.emit)
      lnf_pkg::EMIT_CURSOR: begin
        emit_want = line_hit;
        emit_rs   = 1'b0;
        emit_byte = cursor_byte;
        emit_last = !signed_mode && (len == '0);
      end
      lnf_pkg::EMIT_SIGN: begin
        emit_want = signed_mode;
        emit_byte = value[VAL_W-1] ? lnf_pkg::CHAR_MINUS : lnf_pkg::CHAR_PLUS;
        emit_last = (len == '0);
      end
      lnf_pkg::EMIT_DIGIT: begin
        emit_want = (count != '0);
      end
      default: begin
        emit_want = 1'b0;
      end
    endcase
  end

  assign stall     = emit_want && out_valid && !bus.ready;
  assign st.go     = !stall && (!ctrl.wait_in || in_fire);
  assign emit_fire = st.go && emit_want;
  assign st.count_done = (count == len);
  assign st.count_more = (count > CNT_W'(1));
  assign st.count_zero = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (bus.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        count <= '0;
      end else if (st.go && ctrl.do_push) begin
        count <= count + CNT_W'(1);
      end else if (emit_fire && ctrl.emit == lnf_pkg::EMIT_DIGIT) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode   <= item.opcode;
      line   <= item.line;
      column <= item.column;
      value  <= VAL_W'(item.number);
      len    <= len_sat;
    end
    if (emit_fire) begin
      out_rs   <= emit_rs;
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
    // sign step turns a negative value into its magnitude
    if (emit_fire && ctrl.emit == lnf_pkg::EMIT_SIGN && value[VAL_W-1]) begin
      value <= ~value + VAL_W'(1);
    end
    if (st.go && ctrl.do_mul) begin
      prod <= val32 * lnf_pkg::RECIP_TEN;
    end
    if (st.go && ctrl.do_push) begin
      value    <= q_sel;
      stack[0] <= rem_sel;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end
    if (emit_fire && ctrl.emit == lnf_pkg::EMIT_DIGIT) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  assign bus.valid      = out_valid;
  assign bus.reg_select = out_rs;
  assign bus.bus_byte   = out_byte;
  assign bus.last       = out_last;

endmodule

// ----- design/lcd_number_formatter_unit.sv -----
// lcd_number_formatter_unit: top level of the lcd number formatter
// depends on lnf_pkg, lnf_if, lnf_sequencer, lnf_datapath
//
// usage
// - item channel (lnf_in_if): one word holds mode, line, column, number and
//   digit count; it is taken only while the sequencer sits in its idle step
// - bus channel (lnf_out_if): one word per display write, reg_select low for
//   the set-cursor command, high for sign and digit characters; last marks
//   the final write of an item (an item may give none at all)
// - per item the microcode runs: idle, cursor, sign, then two steps per digit
//   (reciprocal multiply, push), a closing multiply step, then one step per
//   digit out, then one wrap step
// - the multiply and the digit stack take most of an item's steps; the step
//   counter leaves idle when the item is taken, and the output register then
//   registers the first write from its emit step
// - a single output register buffers one write; when the receiver stalls the
//   sequencer holds on its emit step, conversion steps keep running
// - synchronous reset returns the sequencer to idle, empties the output
//   register and clears the digit count; operands and the stack are not reset
module lcd_number_formatter_unit #(
  parameter int MAX_DIGITS  = 16,
  parameter int NUMBER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  lnf_in_if.sink    item,
  lnf_out_if.source bus
);

  lnf_pkg::ctrl_t   ctrl;
  lnf_pkg::status_t st;

  // control: step counter and microcode
  lnf_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .ctrl (ctrl)
  );

  // datapath: operands, divide unit, digit stack, output register
  lnf_datapath #(
    .MAX_DIGITS  (MAX_DIGITS),
    .NUMBER_BITS (NUMBER_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .bus  (bus),
    .ctrl (ctrl),
    .st   (st)
  );

  // an accepted item always leaves the idle step
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item accepted but sequencer stayed idle");

  // the digit stack is empty whenever a new item can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.wait_in |-> st.count_zero)
    else $error("digits left on the stack at idle");

  // a new item is never taken while a digit is still being converted
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.do_push |-> !item.ready)
    else $error("item ready during conversion");

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for lcd_number_formatter_unit
// drives number words and checks each display bus write against a predictor
// depends on lnf_pkg, lnf_if and the rtl of the formatter
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS  = 16;
  localparam int NUMBER_BITS = 16;

  // stimulus sizes
  localparam int RANDOM_ITEMS = 346;
  localparam int CALM_CHUNK   = 50;   // items per stretch of idling or none
  localparam int HOLD_AFTER   = 60;   // words seen before the long receiver stall
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;   // above the worst item latency
  localparam int MAX_REPORTS  = 10;

  // typed rows carry their own expectation, others go through the predictor
  localparam bit CHECKED   = 1'b1;
  localparam bit PREDICTED = 1'b0;
  localparam logic [8:0] NO_CURSOR = 9'h000;

  // one display bus write
  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } bus_word_t;

  // one row of directed stimulus; cursor[8] flags a typed cursor command,
  // text holds the typed characters right-justified, zero bytes unused
  typedef struct packed {
    logic [1:0]   mode;
    logic [1:0]   line;
    logic [4:0]   column;
    logic [15:0]  number;
    logic [4:0]   length;
    bit           typed;
    logic [8:0]   cursor;
    logic [143:0] text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  lnf_in_if  item_ch();
  lnf_out_if bus_ch();

  lcd_number_formatter_unit #(
    .MAX_DIGITS (MAX_DIGITS),
    .NUMBER_BITS(NUMBER_BITS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .item(item_ch),
    .bus (bus_ch)
  );

  always #5ns clk = ~clk;

  // writes still owed by the block, oldest first
  bus_word_t pending_writes[$];
  int        mismatches = 0;
  int        words_seen = 0;
  bit        calm = 1'b0;   // no idling on either side while set
  stim_row_t directed_rows[$];

  // expected run of bus writes for one number word
  function automatic void format_number(input logic [1:0] mode, input logic [1:0] line,
                                        input logic [4:0] column, input logic [15:0] number,
                                        input logic [4:0] length, output bus_word_t writes[$]);
    logic [15:0] mag;
    logic [7:0]  pos;
    logic [7:0]  ch;
    int unsigned n_digits;
    int unsigned radix;
    int unsigned rest;
    int unsigned digit_stack[MAX_DIGITS];
    writes = {};
    mag = number;
    n_digits = (length > MAX_DIGITS) ? MAX_DIGITS : length;

    // cursor address wraps in 8 bits, so column 0 lands on the top address
    pos = {3'b000, column} - 8'd1;
    if (line == lnf_pkg::LINE_ONE) begin
      writes.push_back('{rs: 1'b0, data: lnf_pkg::CMD_SET_CURSOR | pos, last: 1'b0});
    end else if (line == lnf_pkg::LINE_TWO) begin
      pos = pos + lnf_pkg::LINE_TWO_BASE;
      writes.push_back('{rs: 1'b0, data: lnf_pkg::CMD_SET_CURSOR | pos, last: 1'b0});
    end

    // sign, then the magnitude; the most negative value stays 0x8000 = 32768
    if (mode == lnf_pkg::MODE_SDEC) begin
      if (mag[NUMBER_BITS-1]) begin
        writes.push_back('{rs: 1'b1, data: lnf_pkg::CHAR_MINUS, last: 1'b0});
        mag = -mag;
      end else begin
        writes.push_back('{rs: 1'b1, data: lnf_pkg::CHAR_PLUS, last: 1'b0});
      end
    end

    case (mode)
      lnf_pkg::MODE_HEX: radix = 16;
      lnf_pkg::MODE_BIN: radix = 2;
      default:           radix = 10;
    endcase

    rest = mag;
    for (int i = 0; i < n_digits; i++) begin
      digit_stack[i] = rest % radix;
      rest = rest / radix;
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      if (digit_stack[i] < 10) ch = lnf_pkg::CHAR_ZERO + 8'(digit_stack[i]);
      else ch = lnf_pkg::CHAR_UPPER_A + 8'(digit_stack[i] - 10);
      writes.push_back('{rs: 1'b1, data: ch, last: 1'b0});
    end

    if (writes.size() > 0) writes[writes.size()-1].last = 1'b1;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] mode, input logic [1:0] line,
                                       input logic [4:0] column, input logic [15:0] number,
                                       input logic [4:0] length, input bit typed,
                                       input logic [8:0] cursor, input logic [143:0] text);
    stim_row_t r;
    r.mode   = mode;
    r.line   = line;
    r.column = column;
    r.number = number;
    r.length = length;
    r.typed  = typed;
    r.cursor = cursor;
    r.text   = text;
    return r;
  endfunction

  // offer one number word after a random gap, queue its writes once taken
  task automatic send_item(input stim_row_t r);
    int        gap;
    bus_word_t writes[$];
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.opcode <= r.mode;
    item_ch.line   <= r.line;
    item_ch.column <= r.column;
    item_ch.number <= r.number;
    item_ch.length <= r.length;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);

    // word taken at this edge
    if (r.typed) begin
      writes = {};
      if (r.cursor[8]) writes.push_back('{rs: 1'b0, data: r.cursor[7:0], last: 1'b0});
      for (int b = 17; b >= 0; b--) begin
        if (r.text[b*8 +: 8] != 8'h00)
          writes.push_back('{rs: 1'b1, data: r.text[b*8 +: 8], last: 1'b0});
      end
      if (writes.size() > 0) writes[writes.size()-1].last = 1'b1;
    end else begin
      format_number(r.mode, r.line, r.column, r.number, r.length, writes);
    end
    foreach (writes[i]) pending_writes.push_back(writes[i]);
  endtask

  // receiver: random stall per word, one long hold-off to back the block up
  initial begin : bus_sink
    int        stall;
    bit        held_once;
    bus_word_t want;
    bus_word_t got;
    held_once = 1'b0;
    bus_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 14);
      if (!held_once && words_seen >= HOLD_AFTER) begin
        // sender keeps offering meanwhile, so the input must stall
        stall = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (stall > 0) begin
        bus_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      bus_ch.ready <= 1'b1;
      @(posedge clk);
      while (!bus_ch.valid) @(posedge clk);

      got = '{rs: bus_ch.reg_select, data: bus_ch.bus_byte, last: bus_ch.last};
      words_seen++;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected word: rs=%0b byte=%02h last=%0b",
                   got.rs, got.data, got.last);
      end else begin
        want = pending_writes.pop_front();
        if (got.rs !== want.rs || got.data !== want.data || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"word %0d: expected rs=%0b byte=%02h last=%0b, ",
                      "got rs=%0b byte=%02h last=%0b"},
                     words_seen, want.rs, want.data, want.last, got.rs, got.data, got.last);
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    stim_row_t r;
    int        pick;

    rst <= 1'b1;
    item_ch.valid  <= 1'b0;
    item_ch.opcode <= lnf_pkg::MODE_UDEC;
    item_ch.line   <= 2'd0;
    item_ch.column <= 5'd0;
    item_ch.number <= 16'd0;
    item_ch.length <= 5'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of each mode, cursor wrap, zero and saturated lengths
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd1,  5'd1, 16'h0000,  5'd5, CHECKED,
                                   {1'b1, 8'h80}, "00000"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd2, 5'd16, 16'hFFFF,  5'd5, CHECKED,
                                   {1'b1, 8'hCF}, "65535"));
    // most negative value keeps its full magnitude
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd0,  5'd1, 16'h8000,  5'd5, CHECKED,
                                   NO_CURSOR, "-32768"));
    // signed zero shows a plus sign
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd3,  5'd5, 16'h0000,  5'd5, CHECKED,
                                   NO_CURSOR, "+00000"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd1,  5'd3, 16'h7FFF,  5'd5, CHECKED,
                                   {1'b1, 8'h82}, "+32767"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd1,  5'd1, 16'hFFFF,  5'd3, CHECKED,
                                   {1'b1, 8'h80}, "-001"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_HEX,  2'd2,  5'd1, 16'hFFFF,  5'd4, CHECKED,
                                   {1'b1, 8'hC0}, "FFFF"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_HEX,  2'd0,  5'd9, 16'hABCD,  5'd6, CHECKED,
                                   NO_CURSOR, "00ABCD"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_BIN,  2'd1,  5'd1, 16'hA5A5, 5'd16, CHECKED,
                                   {1'b1, 8'h80}, "1010010110100101"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_BIN,  2'd0,  5'd4, 16'hFFFF, 5'd16, CHECKED,
                                   NO_CURSOR, "1111111111111111"));
    // zero length: nothing at all, sign only, cursor only
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd0,  5'd2, 16'h1234,  5'd0, CHECKED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd3,  5'd2, 16'h0005,  5'd0, CHECKED,
                                   NO_CURSOR, "+"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd1,  5'd7, 16'h0042,  5'd0, CHECKED,
                                   {1'b1, 8'h86}, ""));
    // column 0 wraps the cursor address
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd1,  5'd0, 16'h0009,  5'd1, CHECKED,
                                   {1'b1, 8'hFF}, "9"));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd2,  5'd0, 16'h0000,  5'd1, CHECKED,
                                   {1'b1, 8'hBF}, "0"));
    // short length drops the high digits
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd3,  5'd1, 16'd1000,  5'd2, CHECKED,
                                   NO_CURSOR, "00"));
    // columns past the line, long lengths, leading zeros
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd1, 5'd31, 16'd4711,  5'd4, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_HEX,  2'd2, 5'd31, 16'h00FF,  5'd3, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd0,  5'd1, 16'd12345, 5'd31, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_HEX,  2'd1,  5'd2, 16'h1234, 5'd17, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_BIN,  2'd2,  5'd9, 16'h0001, 5'd20, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd1, 5'd12, 16'h8001, 5'd16, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_HEX,  2'd3,  5'd6, 16'h0F00, 5'd16, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_SDEC, 2'd2, 5'd16, 16'hFFFF, 5'd31, PREDICTED,
                                   NO_CURSOR, ""));
    directed_rows.push_back(mk_row(lnf_pkg::MODE_UDEC, 2'd1, 5'd10, 16'd10000, 5'd16, PREDICTED,
                                   NO_CURSOR, ""));

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // random words, alternating stretches with and without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / CALM_CHUNK) % 3) == 1;
      r.typed  = PREDICTED;
      r.cursor = NO_CURSOR;
      r.text   = '0;
      r.mode   = 2'($urandom_range(0, 3));
      r.line   = 2'($urandom_range(0, 3));
      r.column = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 16));
      pick = $urandom_range(0, 9);
      case (pick)
        0:       r.number = 16'h8000;
        1:       r.number = 16'h7FFF;
        2:       r.number = 16'hFFFF;
        3:       r.number = 16'($urandom_range(0, 20));
        default: r.number = 16'($urandom);
      endcase
      r.length = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                             : 5'($urandom_range(0, 16));
      send_item(r);
    end
    item_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain, then allow a late extra write to show up
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin : watchdog
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
design/lnf_pkg.sv
design/lnf_if.sv
design/lnf_sequencer.sv
design/lnf_datapath.sv
design/lcd_number_formatter_unit.sv
bench/tb.sv
